### rtl/utf8rp_pkg.sv
// ----------------------------------------------------------------------------
// utf8rp_pkg: shared types and constants of the UTF-8 reader
// Beat payload structures, result status codes and decoder constants.
// ----------------------------------------------------------------------------
package utf8rp_pkg;

    localparam int unsigned LINE_BITS_DEF   = 24;
    localparam int unsigned COLUMN_BITS_DEF = 20;

    localparam int unsigned RUNE_W   = 21;
    localparam int unsigned LINE_W   = 24;
    localparam int unsigned COLUMN_W = 20;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] NEWLINE     = 8'h0A;
    localparam logic [2:0] MAX_RUNE_BYTES = 3'd4;

    localparam logic [RUNE_W-1:0] RUNE_BAD       = 21'h00FFFD;
    localparam logic [RUNE_W-1:0] BOM_CODE_POINT = 21'h00FEFF;

    // Input beat kinds.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [2:0] {
        ST_RUNE = 3'd0,
        ST_NUL  = 3'd1,
        ST_BAD  = 3'd2,
        ST_BOM  = 3'd3,
        ST_END  = 3'd4
    } status_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        status_t             status;
        logic [RUNE_W-1:0]   rune_value;
        logic [LINE_W-1:0]   line_number;
        logic [COLUMN_W-1:0] column_number;
        logic [2:0]          byte_width;
        logic                last;
    } out_beat_t;

endpackage

### rtl/utf8_reader_with_position.sv
// ----------------------------------------------------------------------------
// utf8_reader_with_position: UTF-8 decoder with line and column tracking
// Decodes a byte stream into runes, flags NUL, invalid bytes and stray BOMs,
// and tags every result with its 1-based line, byte column and width.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload     | Handshake
//  --------+-----------+-------------+------------------
//  s_      | in        | in_beat_t   | s_valid / s_ready
//  m_      | out       | out_beat_t  | m_valid / m_ready
//
// Each accepted beat is decoded in the cycle of its acceptance, and its
// results are loaded into the result register in the same edge.
// Beats that give at most one result can follow one another every cycle
// while m_ready is high. A beat that gives several results holds the result
// register and presents one of them per cycle while m_ready is high.
// The next input beat is taken in the cycle in which the last result of the
// previous one is taken, so no cycle is lost between them.
// Reset is synchronous and active low; it clears the decoder state, the line
// and column counters and the flush count and valid flag of the result
// register. Stalls on m_ready hold the presented result and hold off s_ready.
module utf8_reader_with_position #(
    parameter int unsigned LINE_BITS   = utf8rp_pkg::LINE_BITS_DEF,
    parameter int unsigned COLUMN_BITS = utf8rp_pkg::COLUMN_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  utf8rp_pkg::in_beat_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output utf8rp_pkg::out_beat_t m_data
);
    import utf8rp_pkg::*;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    // Full length of a rune from its lead byte; zero when the byte is no lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= 8'hC2 && b <= 8'hDF) begin
            len = 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            len = 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            len = MAX_RUNE_BYTES;
        end
        return len;
    endfunction

    // Decoder state: the pending bytes of an unfinished rune.
    logic [7:0] pend_b0_reg, pend_b0_next;
    logic [7:0] pend_b1_reg, pend_b1_next;
    logic [7:0] pend_b2_reg, pend_b2_next;
    logic [1:0] pend_cnt_reg, pend_cnt_next;
    logic [2:0] exp_len_reg, exp_len_next;
    logic       finished_reg, finished_next;

    // Position counters, 0-based, for the next rune start.
    logic [LINE_BITS-1:0]   line_cnt_reg, line_cnt_next;
    logic [COLUMN_BITS-1:0] col_cnt_reg, col_cnt_next;

    // Result register. A beat's results are held in compact form: a number
    // of invalid results for flushed pending bytes, which share the line and
    // sit in consecutive columns, and then an optional final result.
    logic [1:0]             flush_left_reg, flush_left_next;
    logic                   tail_valid_reg, tail_valid_next;
    status_t                tail_status_reg, tail_status_next;
    logic [RUNE_W-1:0]      tail_rune_reg, tail_rune_next;
    logic [2:0]             tail_width_reg, tail_width_next;
    logic [LINE_BITS-1:0]   out_line_reg, out_line_next;
    logic [COLUMN_BITS-1:0] out_col_reg, out_col_next;

    // Decode of the offered beat against the current state.
    logic [7:0]        in_byte;
    logic [7:0]        cont_lo;
    logic [7:0]        cont_hi;
    logic              cont_ok;
    logic              lead_path;
    logic [2:0]        new_len;
    logic [RUNE_W-1:0] joined_rune;
    logic [1:0]        dec_nflush;
    logic              dec_tail_valid;
    status_t           dec_tail_status;
    logic [RUNE_W-1:0] dec_tail_rune;
    logic [2:0]        dec_tail_width;
    logic              dec_bom_skip;
    logic              dec_newline;
    logic [2:0]        col_adv;
    logic [COLUMN_BITS:0] col_sum;

    logic s_take;
    logic m_take;
    logic beat_last;

    assign in_byte = s_data.data_byte;
    assign new_len = lead_len(in_byte);

    // Rune value assembled from the pending bytes and the closing byte.
    always_comb begin
        case (exp_len_reg)
            3'd2: joined_rune = RUNE_W'({pend_b0_reg[4:0], in_byte[5:0]});
            3'd3: joined_rune = RUNE_W'({pend_b0_reg[3:0], pend_b1_reg[5:0], in_byte[5:0]});
            default: joined_rune = {pend_b0_reg[2:0], pend_b1_reg[5:0], pend_b2_reg[5:0],
                                    in_byte[5:0]};
        endcase
    end

    // The second byte of a rune has a narrower range for some leads, which
    // rejects overlong forms, surrogates and code points above the maximum.
    always_comb begin
        cont_lo = 8'h80;
        cont_hi = 8'hBF;
        if (pend_cnt_reg == 2'd1) begin
            case (pend_b0_reg)
                8'hE0:   cont_lo = 8'hA0;
                8'hED:   cont_hi = 8'h9F;
                8'hF0:   cont_lo = 8'h90;
                8'hF4:   cont_hi = 8'h8F;
                default: ;
            endcase
        end
    end

    assign cont_ok = (in_byte >= cont_lo) && (in_byte <= cont_hi);

    always_comb begin
        pend_b0_next    = pend_b0_reg;
        pend_b1_next    = pend_b1_reg;
        pend_b2_next    = pend_b2_reg;
        pend_cnt_next   = pend_cnt_reg;
        exp_len_next    = exp_len_reg;
        finished_next   = finished_reg;
        dec_nflush      = 2'd0;
        dec_tail_valid  = 1'b0;
        dec_tail_status = ST_RUNE;
        dec_tail_rune   = '0;
        dec_tail_width  = 3'd0;
        dec_bom_skip    = 1'b0;
        lead_path       = 1'b0;

        if (finished_reg) begin
            // After the end every beat repeats the end result.
            dec_tail_valid  = 1'b1;
            dec_tail_status = ST_END;
        end else if (s_data.op == OP_END) begin
            dec_nflush      = pend_cnt_reg;
            pend_b0_next    = '0;
            pend_b1_next    = '0;
            pend_b2_next    = '0;
            pend_cnt_next   = 2'd0;
            exp_len_next    = 3'd0;
            dec_tail_valid  = 1'b1;
            dec_tail_status = ST_END;
            finished_next   = 1'b1;
        end else if (pend_cnt_reg == 2'd0) begin
            lead_path = 1'b1;
        end else if (!cont_ok) begin
            // Broken sequence: every pending byte is an error, and the new
            // byte starts afresh.
            dec_nflush    = pend_cnt_reg;
            pend_b0_next  = '0;
            pend_b1_next  = '0;
            pend_b2_next  = '0;
            pend_cnt_next = 2'd0;
            exp_len_next  = 3'd0;
            lead_path     = 1'b1;
        end else if ((3'(pend_cnt_reg) + 3'd1) >= exp_len_reg) begin
            pend_b0_next  = '0;
            pend_b1_next  = '0;
            pend_b2_next  = '0;
            pend_cnt_next = 2'd0;
            exp_len_next  = 3'd0;
            if (joined_rune == BOM_CODE_POINT) begin
                if (line_cnt_reg == '0 && col_cnt_reg == '0) begin
                    dec_bom_skip = 1'b1;
                end else begin
                    dec_tail_valid  = 1'b1;
                    dec_tail_status = ST_BOM;
                    dec_tail_rune   = joined_rune;
                    dec_tail_width  = exp_len_reg;
                end
            end else begin
                dec_tail_valid  = 1'b1;
                dec_tail_status = ST_RUNE;
                dec_tail_rune   = joined_rune;
                dec_tail_width  = exp_len_reg;
            end
        end else begin
            if (pend_cnt_reg == 2'd1) begin
                pend_b1_next = in_byte;
            end else begin
                pend_b2_next = in_byte;
            end
            pend_cnt_next = pend_cnt_reg + 2'd1;
        end

        if (lead_path) begin
            if (in_byte < ASCII_LIMIT) begin
                dec_tail_valid  = 1'b1;
                dec_tail_width  = 3'd1;
                if (in_byte == 8'h00) begin
                    dec_tail_status = ST_NUL;
                end else begin
                    dec_tail_status = ST_RUNE;
                    dec_tail_rune   = RUNE_W'(in_byte);
                end
            end else if (new_len != 3'd0) begin
                pend_b0_next  = in_byte;
                pend_b1_next  = '0;
                pend_b2_next  = '0;
                pend_cnt_next = 2'd1;
                exp_len_next  = new_len;
            end else begin
                dec_tail_valid  = 1'b1;
                dec_tail_status = ST_BAD;
                dec_tail_rune   = RUNE_BAD;
                dec_tail_width  = 3'd1;
            end
        end
    end

    // Position update for the whole beat. Only the final result can be a
    // newline, so the flushed bytes always advance the column of one line.
    assign dec_newline = dec_tail_valid && (dec_tail_status == ST_RUNE)
                         && (dec_tail_rune == RUNE_W'(NEWLINE));
    assign col_adv = 3'(dec_nflush)
                     + (dec_tail_valid ? dec_tail_width : (dec_bom_skip ? 3'd3 : 3'd0));
    assign col_sum = {1'b0, col_cnt_reg} + (COLUMN_BITS+1)'(col_adv);

    always_comb begin
        line_cnt_next = line_cnt_reg;
        if (dec_newline) begin
            col_cnt_next = '0;
            if (line_cnt_reg != LINE_MAX) begin
                line_cnt_next = line_cnt_reg + 1'b1;
            end
        end else if (col_sum[COLUMN_BITS]) begin
            col_cnt_next = COL_MAX;
        end else begin
            col_cnt_next = col_sum[COLUMN_BITS-1:0];
        end
    end

    // Output side. The last result of a beat is the final result if there is
    // one, else the last flushed byte.
    assign m_valid   = (flush_left_reg != 2'd0) || tail_valid_reg;
    assign beat_last = (flush_left_reg == 2'd0) || ((flush_left_reg == 2'd1) && !tail_valid_reg);
    assign m_take    = m_valid && m_ready;
    assign s_ready   = !m_valid || (m_ready && beat_last);
    assign s_take    = s_valid && s_ready;

    always_comb begin
        m_data.line_number   = LINE_W'(out_line_reg);
        m_data.column_number = COLUMN_W'(out_col_reg);
        m_data.last          = beat_last;
        if (flush_left_reg != 2'd0) begin
            m_data.status     = ST_BAD;
            m_data.rune_value = RUNE_BAD;
            m_data.byte_width = 3'd1;
        end else begin
            m_data.status     = tail_status_reg;
            m_data.rune_value = tail_rune_reg;
            m_data.byte_width = tail_width_reg;
        end
    end

    always_comb begin
        flush_left_next  = flush_left_reg;
        tail_valid_next  = tail_valid_reg;
        tail_status_next = tail_status_reg;
        tail_rune_next   = tail_rune_reg;
        tail_width_next  = tail_width_reg;
        out_line_next    = out_line_reg;
        out_col_next     = out_col_reg;
        if (s_take) begin
            flush_left_next  = dec_nflush;
            tail_valid_next  = dec_tail_valid;
            tail_status_next = dec_tail_status;
            tail_rune_next   = dec_tail_rune;
            tail_width_next  = dec_tail_width;
            out_line_next    = (line_cnt_reg == LINE_MAX) ? LINE_MAX : line_cnt_reg + 1'b1;
            out_col_next     = (col_cnt_reg == COL_MAX) ? COL_MAX : col_cnt_reg + 1'b1;
        end else if (m_take) begin
            if (flush_left_reg != 2'd0) begin
                // Each flushed byte is one column wide.
                flush_left_next = flush_left_reg - 2'd1;
                if (out_col_reg != COL_MAX) begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end else begin
                tail_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_b0_reg    <= '0;
            pend_b1_reg    <= '0;
            pend_b2_reg    <= '0;
            pend_cnt_reg   <= 2'd0;
            exp_len_reg    <= 3'd0;
            finished_reg   <= 1'b0;
            line_cnt_reg   <= '0;
            col_cnt_reg    <= '0;
            flush_left_reg <= 2'd0;
            tail_valid_reg <= 1'b0;
        end else begin
            if (s_take) begin
                pend_b0_reg  <= pend_b0_next;
                pend_b1_reg  <= pend_b1_next;
                pend_b2_reg  <= pend_b2_next;
                pend_cnt_reg <= pend_cnt_next;
                exp_len_reg  <= exp_len_next;
                finished_reg <= finished_next;
                line_cnt_reg <= line_cnt_next;
                col_cnt_reg  <= col_cnt_next;
            end
            flush_left_reg <= flush_left_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tail_status_reg <= tail_status_next;
        tail_rune_reg   <= tail_rune_next;
        tail_width_reg  <= tail_width_next;
        out_line_reg    <= out_line_next;
        out_col_reg     <= out_col_next;
    end

`ifndef SYNTH
    a_flush_is_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (flush_left_reg != 2'd0) |-> (m_data.status == ST_BAD))
        else $error("flushed byte presented with a status other than invalid");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> !s_ready)
        else $error("input taken while results of the previous beat remain");

    a_end_repeats: assert property (@(posedge aclk) disable iff (!aresetn)
        (finished_reg && s_take) |=> (m_valid && m_data.last && m_data.status == ST_END))
        else $error("beat after end of input did not give a single end result");

    a_no_pending_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> (pend_cnt_reg == 2'd0))
        else $error("pending bytes left after end of input");

    a_pending_shorter: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_cnt_reg != 2'd0) |-> (exp_len_reg > 3'(pend_cnt_reg)))
        else $error("pending byte count reached the rune length");
`endif

endmodule
